@@ hdl/dtort_pkg.sv @@
// Shared types and constants for the delay-then-on relay timer.
// No dependencies; the top level refers to it by scoped names.
package dtort_pkg;

  typedef enum logic [1:0] {
    MODE_SET_ON    = 2'd0,
    MODE_SET_DELAY = 2'd1,
    MODE_DELAY_CNT = 2'd2,
    MODE_ON_CNT    = 2'd3
  } mode_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned MaxMinW  = 14;
  localparam int unsigned TpsW     = 10;
  localparam int unsigned SecW     = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_MINUTES        = 2'd0,
    CFG_TICKS_PER_SECOND   = 2'd1,
    CFG_SECONDS_PER_MINUTE = 2'd2,
    CFG_UNUSED             = 2'd3
  } cfg_idx_e;

  localparam logic [MaxMinW-1:0] MaxMinReset = 14'd5999;
  localparam logic [TpsW-1:0]    TpsReset    = 10'd200;
  localparam logic [SecW-1:0]    SpmReset    = 8'd60;

  localparam int unsigned InDataW = 8;
  localparam int unsigned InUserW = 1;

endpackage

@@ hdl/delay_then_on_relay_timer.sv @@
// Delay-then-on relay timer: mode control, minute editing, second prescaler
// and countdowns. Depends on dtort_pkg.
//
// Usage:
//   Input stream (s_axis_*): one beat per event. tuser = operation
//   (0 timer tick, 1 key scan); tdata[0] key_up, tdata[1] key_down.
//   Output stream (m_axis_*): exactly one result beat per input beat, giving
//   mode, relay drive, the three lamps and the minutes of the current mode.
//   Configuration (cfg_*): register index and data, always ready; write only
//   while no result is outstanding.
// Latency and throughput:
//   A result is registered and appears in the cycle after its input beat.
//   One beat per cycle is sustained while m_axis_tready_i is high: state
//   update and result are combinational between state and output registers.
// Reset:
//   rst_ni clears mode, minutes, prescaler, seconds, relay, lamp and release
//   wait, and loads the configuration defaults (5999 minutes, 200 ticks per
//   second, 60 seconds per minute).
// Stall:
//   While a result waits on m_axis_tready_i, s_axis_tready_o stays low;
//   in the cycle the result is taken a new beat can be accepted.
module delay_then_on_relay_timer #(
  parameter int unsigned MINUTE_WIDTH = 14
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // [0] key_up, [1] key_down, rest zero
  input  logic [dtort_pkg::InDataW-1:0]          s_axis_tdata_i,
  // [0] operation
  input  logic [dtort_pkg::InUserW-1:0]          s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // [1:0] mode, [2] relay_drive, [3] lamp_one, [4] lamp_two, [5] lamp_three,
  // [6 +: MINUTE_WIDTH] shown_minutes, rest zero
  output logic [((MINUTE_WIDTH+6+7)/8)*8-1:0]    m_axis_tdata_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dtort_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [dtort_pkg::CfgDataW-1:0]         cfg_data_i
);

  localparam int unsigned MinW  = MINUTE_WIDTH;
  localparam int unsigned OutW  = ((MinW + 6 + 7) / 8) * 8;
  localparam int unsigned CmpW  = (MinW + 1 > dtort_pkg::MaxMinW) ? MinW + 1
                                                                  : dtort_pkg::MaxMinW;
  localparam int unsigned MaxMinW = dtort_pkg::MaxMinW;
  localparam int unsigned TpsW    = dtort_pkg::TpsW;
  localparam int unsigned SecW    = dtort_pkg::SecW;

  logic [MaxMinW-1:0] max_min_q;
  logic [TpsW-1:0]    tps_q;
  logic [SecW-1:0]    spm_q;

  dtort_pkg::mode_e   mode_q, mode_d;
  logic [MinW-1:0]    on_min_q, on_min_d;
  logic [MinW-1:0]    dly_min_q, dly_min_d;
  logic [TpsW-1:0]    presc_q, presc_d;
  logic [SecW-1:0]    dly_sec_q, dly_sec_d;
  logic [SecW-1:0]    on_sec_q, on_sec_d;
  logic               relay_q, relay_d;
  logic               blink_q, blink_d;
  logic               release_q, release_d;

  logic               out_valid_q;
  logic [OutW-1:0]    out_data_q, out_data_d;

  logic               in_fire;
  logic               op, key_up, key_down;
  logic [TpsW-1:0]    presc_inc;
  logic [SecW-1:0]    dly_sec_inc, on_sec_inc;
  logic [MinW-1:0]    edit_val, edit_inc, edit_dec, dly_min_dec, on_min_dec;
  logic [MinW:0]      edit_sum;
  logic               edit_wrap;
  logic               show_on;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = s_axis_tuser_i[0];
  assign key_up          = s_axis_tdata_i[0];
  assign key_down        = s_axis_tdata_i[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_min_q <= dtort_pkg::MaxMinReset;
      tps_q     <= dtort_pkg::TpsReset;
      spm_q     <= dtort_pkg::SpmReset;
    end else if (cfg_valid_i) begin
      case (dtort_pkg::cfg_idx_e'(cfg_index_i))
        dtort_pkg::CFG_MAX_MINUTES:        max_min_q <= cfg_data_i[MaxMinW-1:0];
        dtort_pkg::CFG_TICKS_PER_SECOND:   tps_q     <= cfg_data_i[TpsW-1:0];
        dtort_pkg::CFG_SECONDS_PER_MINUTE: spm_q     <= cfg_data_i[SecW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_d    = mode_q;
    on_min_d  = on_min_q;
    dly_min_d = dly_min_q;
    presc_d   = presc_q;
    dly_sec_d = dly_sec_q;
    on_sec_d  = on_sec_q;
    relay_d   = relay_q;
    blink_d   = blink_q;
    release_d = release_q;

    presc_inc   = presc_q + 1'b1;
    dly_sec_inc = dly_sec_q + 1'b1;
    on_sec_inc  = on_sec_q + 1'b1;
    dly_min_dec = (dly_min_q != '0) ? dly_min_q - 1'b1 : '0;
    on_min_dec  = (on_min_q != '0) ? on_min_q - 1'b1 : '0;

    edit_val  = (mode_q == dtort_pkg::MODE_SET_ON) ? on_min_q : dly_min_q;
    edit_sum  = {1'b0, edit_val} + 1'b1;
    edit_wrap = edit_sum[MinW] ||
                (CmpW'(edit_sum) > CmpW'(max_min_q));
    edit_inc  = edit_wrap ? '0 : edit_sum[MinW-1:0];
    edit_dec  = (edit_val != '0) ? edit_val - 1'b1 : '0;

    if (!op) begin
      // tick: advance the prescaler, count a second on reaching the limit
      presc_d = presc_inc;
      if (presc_inc >= tps_q) begin
        presc_d = '0;
        case (mode_q)
          dtort_pkg::MODE_DELAY_CNT: begin
            blink_d = !blink_q;
            if (dly_min_q == '0) begin
              mode_d = dtort_pkg::MODE_ON_CNT;
            end
            if (dly_sec_inc >= spm_q) begin
              dly_sec_d = '0;
              dly_min_d = dly_min_dec;
              if (dly_min_dec == '0) begin
                mode_d = dtort_pkg::MODE_ON_CNT;
              end
            end else begin
              dly_sec_d = dly_sec_inc;
            end
          end
          dtort_pkg::MODE_ON_CNT: begin
            blink_d = !blink_q;
            relay_d = (on_min_q != '0);
            if (on_min_q == '0) begin
              mode_d = dtort_pkg::MODE_SET_ON;
            end
            if (on_sec_inc >= spm_q) begin
              on_sec_d = '0;
              on_min_d = on_min_dec;
              if (on_min_dec == '0) begin
                relay_d = 1'b0;
                mode_d  = dtort_pkg::MODE_SET_ON;
              end
            end else begin
              on_sec_d = on_sec_inc;
            end
          end
          default: ;
        endcase
      end
    end else if (release_q) begin
      if (!key_up && !key_down) begin
        release_d = 1'b0;
      end
    end else begin
      case (mode_q)
        dtort_pkg::MODE_SET_ON, dtort_pkg::MODE_SET_DELAY: begin
          if (key_up && key_down) begin
            mode_d    = (mode_q == dtort_pkg::MODE_SET_ON) ? dtort_pkg::MODE_SET_DELAY
                                                           : dtort_pkg::MODE_DELAY_CNT;
            release_d = 1'b1;
          end else if (key_up || key_down) begin
            if (mode_q == dtort_pkg::MODE_SET_ON) begin
              on_min_d = key_up ? edit_inc : edit_dec;
            end else begin
              dly_min_d = key_up ? edit_inc : edit_dec;
            end
          end
        end
        default: begin
          if (key_up || key_down) begin
            on_min_d  = '0;
            dly_min_d = '0;
            relay_d   = 1'b0;
            mode_d    = dtort_pkg::MODE_SET_ON;
            release_d = 1'b1;
          end
        end
      endcase
    end

    show_on    = (mode_d == dtort_pkg::MODE_SET_ON) || (mode_d == dtort_pkg::MODE_ON_CNT);
    out_data_d = '0;
    out_data_d[1:0]       = mode_d;
    out_data_d[2]         = relay_d;
    out_data_d[3]         = show_on;
    out_data_d[4]         = !show_on;
    out_data_d[5]         = mode_d[1] && blink_d;
    out_data_d[6 +: MinW] = show_on ? on_min_d : dly_min_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= dtort_pkg::MODE_SET_ON;
      on_min_q  <= '0;
      dly_min_q <= '0;
      presc_q   <= '0;
      dly_sec_q <= '0;
      on_sec_q  <= '0;
      relay_q   <= 1'b0;
      blink_q   <= 1'b0;
      release_q <= 1'b0;
    end else if (in_fire) begin
      mode_q    <= mode_d;
      on_min_q  <= on_min_d;
      dly_min_q <= dly_min_d;
      presc_q   <= presc_d;
      dly_sec_q <= dly_sec_d;
      on_sec_q  <= on_sec_d;
      relay_q   <= relay_d;
      blink_q   <= blink_d;
      release_q <= release_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_relay_only_on_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    relay_q |-> (mode_q == dtort_pkg::MODE_ON_CNT))
    else $error("relay energized outside on countdown");

  a_release_from_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(release_q) |-> $past(in_fire && op))
    else $error("release wait set without a key beat");

  a_state_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_fire) |-> ($stable(mode_q) && $stable(on_min_q) && $stable(dly_min_q)))
    else $error("timer state changed without an input beat");

  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_fire) |-> (out_data_q[1:0] == mode_q && out_data_q[2] == relay_q))
    else $error("result beat disagrees with timer state");

endmodule
